[hw/rtl/s0pm_pkg.sv]
// Shared constants, codes and types of the S0 pulse meter block.
package s0pm_pkg;

  localparam int unsigned CHANNELS = 3;

  // Item field widths.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned ENERGY_W = 64;
  localparam int unsigned MS_W     = 23;
  localparam int unsigned POWER_W  = 32;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd1;
  localparam logic [TIME_W-1:0]    DEBOUNCE_RESET = 32'd30000;

  // Action codes; the unused code behaves as a read.
  localparam logic [ACTION_W-1:0] ACT_LEVEL  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PRESET = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  // x / 1000 for any 32-bit x equals (x * MS_MAGIC) >> MS_SHIFT.
  localparam int unsigned MAGIC_W  = 29;
  localparam logic [MAGIC_W-1:0] MS_MAGIC = 29'h10624DD3;
  localparam int unsigned MS_SHIFT = 38;
  localparam int unsigned PROD_W   = TIME_W + MAGIC_W;

  // Power numerator: watt-microseconds in one watt-hour.
  localparam logic [TIME_W-1:0] POWER_NUM = 32'd3600000000;

  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

  typedef struct packed {
    logic load;      // capture the accepted input word
    logic update;    // apply the action and take the channel snapshot
    logic mul_age;   // multiply the pulse age by the reciprocal
    logic mul_iv;    // keep the age in ms, multiply the interval
    logic div_init;  // start the power division
    logic div_step;  // one quotient bit
    logic out_load;  // move the finished result into the output register
  } s0pm_cmd_t;

  typedef struct packed {
    logic div_last;  // the current step produces the final quotient bit
  } s0pm_sts_t;

  typedef struct packed {
    logic                accepted;
    logic                active;
    logic                level_high_res;
    logic [COUNT_W-1:0]  rising_count;
    logic [COUNT_W-1:0]  falling_count;
    logic [COUNT_W-1:0]  pulse_count;
    logic [ENERGY_W-1:0] energy_wh;
    logic                has_pulse;
    logic [MS_W-1:0]     pulse_age_ms;
    logic                has_power;
    logic [MS_W-1:0]     interval_ms;
    logic [POWER_W-1:0]  power_w;
  } s0pm_res_t;

endpackage

[hw/rtl/s0pm_if.sv]
// Handshake interfaces of the S0 pulse meter: input words, results and configuration.
interface s0pm_in_if;
  logic                              valid;
  logic                              ready;
  logic [s0pm_pkg::ACTION_W-1:0]     action;
  logic [s0pm_pkg::CH_W-1:0]         channel;
  logic                              level_high;
  logic [s0pm_pkg::TIME_W-1:0]       now_us;
  logic [s0pm_pkg::ENERGY_W-1:0]     energy_preset;

  modport source (output valid, action, channel, level_high, now_us, energy_preset,
                  input ready);
  modport sink   (input valid, action, channel, level_high, now_us, energy_preset,
                  output ready);
endinterface

interface s0pm_out_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic                              active;
  logic                              level_high_res;
  logic [s0pm_pkg::COUNT_W-1:0]      rising_count;
  logic [s0pm_pkg::COUNT_W-1:0]      falling_count;
  logic [s0pm_pkg::COUNT_W-1:0]      pulse_count;
  logic [s0pm_pkg::ENERGY_W-1:0]     energy_wh;
  logic                              has_pulse;
  logic [s0pm_pkg::MS_W-1:0]         pulse_age_ms;
  logic                              has_power;
  logic [s0pm_pkg::MS_W-1:0]         interval_ms;
  logic [s0pm_pkg::POWER_W-1:0]      power_w;

  modport source (output valid, accepted, active, level_high_res, rising_count,
                  falling_count, pulse_count, energy_wh, has_pulse, pulse_age_ms,
                  has_power, interval_ms, power_w,
                  input ready);
  modport sink   (input valid, accepted, active, level_high_res, rising_count,
                  falling_count, pulse_count, energy_wh, has_pulse, pulse_age_ms,
                  has_power, interval_ms, power_w,
                  output ready);
endinterface

interface s0pm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [s0pm_pkg::CFG_IDX_W-1:0]    index;
  logic [s0pm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/s0pm_ctrl.sv]
// Sequencer of the S0 pulse meter: input and output handshakes and datapath commands.
module s0pm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  s0pm_pkg::s0pm_sts_t sts_i,
  output s0pm_pkg::s0pm_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MULA = 3'd2;
  localparam logic [2:0] S_MULB = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new word when empty or being emptied now.
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_MULA;
      end
      S_MULA: begin
        cmd_o.mul_age  = 1'b1;
        cmd_o.div_init = 1'b1;
        state_d        = S_MULB;
      end
      S_MULB: begin
        cmd_o.mul_iv   = 1'b1;
        cmd_o.div_step = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hw/rtl/s0pm_dp.sv]
// Datapath of the S0 pulse meter: channel state, configuration, scaling and power divider.
module s0pm_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  s0pm_pkg::s0pm_cmd_t                 cmd_i,
  output s0pm_pkg::s0pm_sts_t                 sts_o,
  input  logic [s0pm_pkg::ACTION_W-1:0]       action_i,
  input  logic [s0pm_pkg::CH_W-1:0]           channel_i,
  input  logic                                level_high_i,
  input  logic [s0pm_pkg::TIME_W-1:0]         now_us_i,
  input  logic [s0pm_pkg::ENERGY_W-1:0]       energy_preset_i,
  input  logic                                cfg_we_i,
  input  logic [s0pm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [s0pm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output s0pm_pkg::s0pm_res_t                 res_o
);

  localparam int unsigned TW = s0pm_pkg::TIME_W;
  localparam int unsigned CW = s0pm_pkg::COUNT_W;
  localparam int unsigned EW = s0pm_pkg::ENERGY_W;
  localparam int unsigned NC = s0pm_pkg::CHANNELS;

  // Configuration registers.
  logic [TW-1:0] debounce_q;
  logic          active_low_q;

  // Per-channel state.
  logic          raw_q        [NC];
  logic [TW-1:0] last_edge_q  [NC];
  logic [CW-1:0] rising_q     [NC];
  logic [CW-1:0] falling_q    [NC];
  logic [CW-1:0] pulses_q     [NC];
  logic [EW-1:0] energy_q     [NC];
  logic [TW-1:0] last_pulse_q [NC];
  logic [TW-1:0] interval_q   [NC];

  // Captured input word.
  logic [s0pm_pkg::ACTION_W-1:0] action_q;
  logic [s0pm_pkg::CH_W-1:0]     ch_q;
  logic                          lvl_q;
  logic [TW-1:0]                 now_q;
  logic [EW-1:0]                 preset_q;

  // Snapshot after the action.
  logic          ok_s_q, acc_s_q, raw_s_q;
  logic [CW-1:0] rise_s_q, fall_s_q, pulse_s_q;
  logic [EW-1:0] energy_s_q;
  logic [TW-1:0] lp_s_q, iv_s_q, age_q;

  // Scaling and division.
  logic [s0pm_pkg::PROD_W-1:0]    prod_q;
  logic [s0pm_pkg::MS_W-1:0]      age_ms_q;
  logic [TW-1:0]                  rem_q, quo_q;
  logic [s0pm_pkg::DIV_CNT_W-1:0] cnt_q;

  s0pm_pkg::s0pm_res_t res_q;

  // Update logic for the selected channel.
  logic          ch_ok;
  logic          cur_raw;
  logic [TW-1:0] cur_edge, cur_lp, cur_iv;
  logic [CW-1:0] cur_rise, cur_fall, cur_pulse;
  logic [EW-1:0] cur_energy;
  logic          is_level, changed, settled, acc, pulse_edge;
  logic          new_raw;
  logic [TW-1:0] new_edge, new_lp, new_iv;
  logic [CW-1:0] new_rise, new_fall, new_pulse;
  logic [EW-1:0] new_energy;

  assign ch_ok      = (ch_q < s0pm_pkg::CH_W'(NC));
  assign cur_raw    = raw_q[ch_q];
  assign cur_edge   = last_edge_q[ch_q];
  assign cur_rise   = rising_q[ch_q];
  assign cur_fall   = falling_q[ch_q];
  assign cur_pulse  = pulses_q[ch_q];
  assign cur_energy = energy_q[ch_q];
  assign cur_lp     = last_pulse_q[ch_q];
  assign cur_iv     = interval_q[ch_q];

  assign is_level   = (action_q == s0pm_pkg::ACT_LEVEL);
  assign changed    = is_level && (lvl_q != cur_raw);
  // Wrapping time difference against the debounce window.
  assign settled    = ((now_q - cur_edge) >= debounce_q);
  assign acc        = changed && settled;
  assign pulse_edge = acc && (lvl_q ^ active_low_q);

  always_comb begin
    new_raw    = changed ? lvl_q : cur_raw;
    new_edge   = acc ? now_q : cur_edge;
    new_rise   = cur_rise + CW'(acc && lvl_q);
    new_fall   = cur_fall + CW'(acc && !lvl_q);
    new_pulse  = cur_pulse + CW'(pulse_edge);
    new_lp     = pulse_edge ? now_q : cur_lp;
    new_iv     = (pulse_edge && (cur_lp != '0)) ? (now_q - cur_lp) : cur_iv;
    new_energy = cur_energy + EW'(pulse_edge);
    if (action_q == s0pm_pkg::ACT_PRESET) begin
      new_energy = preset_q;
    end
  end

  // Restoring divider step for POWER_NUM / interval.
  logic [TW:0] div_shift, div_sub;
  logic        div_ge;

  assign div_shift = {rem_q, quo_q[TW-1]};
  assign div_ge    = (div_shift >= {1'b0, iv_s_q});
  assign div_sub   = div_shift - {1'b0, iv_s_q};

  assign sts_o.div_last = (cnt_q == s0pm_pkg::DIV_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= s0pm_pkg::DEBOUNCE_RESET;
      active_low_q <= 1'b1;
      for (int i = 0; i < NC; i++) begin
        raw_q[i]        <= 1'b1;
        last_edge_q[i]  <= '0;
        rising_q[i]     <= '0;
        falling_q[i]    <= '0;
        pulses_q[i]     <= '0;
        energy_q[i]     <= '0;
        last_pulse_q[i] <= '0;
        interval_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          s0pm_pkg::CFG_DEBOUNCE:   debounce_q   <= cfg_data_i[TW-1:0];
          s0pm_pkg::CFG_ACTIVE_LOW: active_low_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.update && ch_ok) begin
        raw_q[ch_q]        <= new_raw;
        last_edge_q[ch_q]  <= new_edge;
        rising_q[ch_q]     <= new_rise;
        falling_q[ch_q]    <= new_fall;
        pulses_q[ch_q]     <= new_pulse;
        energy_q[ch_q]     <= new_energy;
        last_pulse_q[ch_q] <= new_lp;
        interval_q[ch_q]   <= new_iv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      ch_q     <= channel_i;
      lvl_q    <= level_high_i;
      now_q    <= now_us_i;
      preset_q <= energy_preset_i;
    end
    if (cmd_i.update) begin
      ok_s_q     <= ch_ok;
      acc_s_q    <= acc;
      raw_s_q    <= new_raw;
      rise_s_q   <= new_rise;
      fall_s_q   <= new_fall;
      pulse_s_q  <= new_pulse;
      energy_s_q <= new_energy;
      lp_s_q     <= new_lp;
      iv_s_q     <= new_iv;
      age_q      <= now_q - new_lp;
    end
    if (cmd_i.mul_age) begin
      prod_q <= s0pm_pkg::PROD_W'(age_q) * s0pm_pkg::PROD_W'(s0pm_pkg::MS_MAGIC);
    end
    if (cmd_i.mul_iv) begin
      age_ms_q <= prod_q[s0pm_pkg::PROD_W-1:s0pm_pkg::MS_SHIFT];
      prod_q   <= s0pm_pkg::PROD_W'(iv_s_q) * s0pm_pkg::PROD_W'(s0pm_pkg::MS_MAGIC);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= s0pm_pkg::POWER_NUM;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_sub[TW-1:0] : div_shift[TW-1:0];
      quo_q <= {quo_q[TW-2:0], div_ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      if (ok_s_q) begin
        res_q.accepted       <= acc_s_q;
        res_q.active         <= raw_s_q ^ active_low_q;
        res_q.level_high_res <= raw_s_q;
        res_q.rising_count   <= rise_s_q;
        res_q.falling_count  <= fall_s_q;
        res_q.pulse_count    <= pulse_s_q;
        res_q.energy_wh      <= energy_s_q;
        res_q.has_pulse      <= (lp_s_q != '0);
        res_q.pulse_age_ms   <= (lp_s_q != '0) ? age_ms_q : '0;
        res_q.has_power      <= (iv_s_q != '0);
        res_q.interval_ms    <= (iv_s_q != '0) ?
                                prod_q[s0pm_pkg::PROD_W-1:s0pm_pkg::MS_SHIFT] : '0;
        res_q.power_w        <= (iv_s_q != '0) ? quo_q : '0;
      end else begin
        res_q <= '0;
      end
    end
  end

  assign res_o = res_q;

endmodule

[hw/rtl/s0_pulse_meter_channels.sv]
// Top level of the three-channel S0 pulse meter.
// Usage: each input word on in_i is one action for one channel: a sampled pin
// level with its microsecond timestamp, an energy preset, or a read. Every
// accepted word yields exactly one result word on out_o with the channel's
// counts, energy, pulse age, last interval and power after the action.
// The configuration channel cfg_i writes the debounce time (index 0) and the
// active-low flag (index 1); it is always ready and should only be used while
// no word is in flight. Other indexes are ignored.
// Sequence: once a word is accepted, the channel is updated, then the pulse
// age is scaled and the divider loaded, then a one-bit-per-cycle divider
// works out the power figure (the interval is scaled during its first step),
// and finally the result is moved into the output register. A new word is
// taken in the cycle after the previous result is registered, so the block
// does not accept a new word while one is being worked on.
// The output register holds a result until it is taken; a new word may be
// accepted and worked on meanwhile, and waits at the end for that register.
// Reset restores the debounce time to 30000 us, active-low mode, all pins
// idle high and all counters, times and energies to zero.
module s0_pulse_meter_channels (
  input  logic        clk_i,
  input  logic        rst_ni,
  s0pm_in_if.sink     in_i,
  s0pm_out_if.source  out_o,
  s0pm_cfg_if.sink    cfg_i
);

  s0pm_pkg::s0pm_cmd_t cmd;
  s0pm_pkg::s0pm_sts_t sts;
  s0pm_pkg::s0pm_res_t res;

  assign cfg_i.ready = 1'b1;

  s0pm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  s0pm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (in_i.action),
    .channel_i       (in_i.channel),
    .level_high_i    (in_i.level_high),
    .now_us_i        (in_i.now_us),
    .energy_preset_i (in_i.energy_preset),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .res_o           (res)
  );

  assign out_o.accepted       = res.accepted;
  assign out_o.active         = res.active;
  assign out_o.level_high_res = res.level_high_res;
  assign out_o.rising_count   = res.rising_count;
  assign out_o.falling_count  = res.falling_count;
  assign out_o.pulse_count    = res.pulse_count;
  assign out_o.energy_wh      = res.energy_wh;
  assign out_o.has_pulse      = res.has_pulse;
  assign out_o.pulse_age_ms   = res.pulse_age_ms;
  assign out_o.has_power      = res.has_power;
  assign out_o.interval_ms    = res.interval_ms;
  assign out_o.power_w        = res.power_w;

endmodule
